// File: src/tgc_pkg.sv
// Shared types, codes and defaults for the touch gesture classifier.
// Used by every module of the block but the queue; depends on nothing else.
package tgc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS      = 32;
    localparam int IVAL_BITS      = 24;

    localparam logic [IVAL_BITS-1:0] IVAL_RESET = 24'd300000;

    // Item kind carried in tuser on the input side.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Reader status codes.
    localparam logic [1:0] RS_BUSY     = 2'd0;
    localparam logic [1:0] RS_PEN_UP   = 2'd1;
    localparam logic [1:0] RS_COMPLETE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PRESS   = 3'd1,
        ST_HELD    = 3'd2,
        ST_RELEASE = 3'd3,
        ST_DOUBLE  = 3'd4
    } t_status;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_PEN_UP = 2'd1,
        CMD_TOUCH  = 2'd2
    } t_cmd;

    function automatic logic pen_down(t_status s);
        return (s == ST_PRESS) || (s == ST_HELD) || (s == ST_DOUBLE);
    endfunction

endpackage

// File: src/tgc_front.sv
// Front end: takes input transfers, sorts them into commands and drops
// readings in progress. Depends on tgc_pkg.
module tgc_front #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [1:0]                   i_read_status,
    input  logic [COORD_BITS-1:0]        i_x,
    input  logic [COORD_BITS-1:0]        i_y,
    input  logic [tgc_pkg::TIME_BITS-1:0] i_time,
    output logic                         o_push,
    output tgc_pkg::t_cmd                o_cmd,
    output logic [COORD_BITS-1:0]        o_x,
    output logic [COORD_BITS-1:0]        o_y,
    output logic [tgc_pkg::TIME_BITS-1:0] o_time,
    input  logic                         i_q_ready
);
    import tgc_pkg::*;

    logic keep;

    always_comb begin
        keep  = 1'b1;
        o_cmd = CMD_READ;
        if (i_op == OP_READ) begin
            o_cmd = CMD_READ;
        end else begin
            case (i_read_status)
                RS_PEN_UP:   o_cmd = CMD_PEN_UP;
                RS_COMPLETE: o_cmd = CMD_TOUCH;
                default: begin
                    // A reading in progress, or the unused code, changes nothing.
                    keep = 1'b0;
                end
            endcase
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready && keep;
    assign o_x     = i_x;
    assign o_y     = i_y;
    assign o_time  = i_time;

endmodule

// File: src/tgc_queue.sv
// Two-entry queue between the front and the back end.
// Generic payload; depends on nothing else.
module tgc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = i_push ? ~r_wr : r_wr;
        n_rd  = do_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: src/tgc_back.sv
// Back end: holds the gesture state and the published record, carries out
// commands and drives the output register. Depends on tgc_pkg.
module tgc_back #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tgc_pkg::IVAL_BITS-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  tgc_pkg::t_cmd                 i_cmd,
    input  logic [COORD_BITS-1:0]         i_x,
    input  logic [COORD_BITS-1:0]         i_y,
    input  logic [tgc_pkg::TIME_BITS-1:0] i_time,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_fresh,
    output tgc_pkg::t_status              o_status,
    output logic [COORD_BITS-1:0]         o_x,
    output logic [COORD_BITS-1:0]         o_y,
    output logic [COORD_BITS:0]           o_dx,
    output logic [COORD_BITS:0]           o_dy
);
    import tgc_pkg::*;

    logic [IVAL_BITS-1:0] r_ival;
    t_status              r_prev, n_prev;
    t_status              r_pub, n_pub;
    logic [COORD_BITS-1:0] r_pub_x, n_pub_x, r_pub_y, n_pub_y;
    logic [COORD_BITS:0]   r_pub_dx, n_pub_dx, r_pub_dy, n_pub_dy;
    logic [COORD_BITS-1:0] r_anc_x, n_anc_x, r_anc_y, n_anc_y;
    logic                 r_unread, n_unread;
    logic [TIME_BITS-1:0] r_last_t, n_last_t;
    logic                 r_seen, n_seen;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_fresh, n_out_fresh;
    t_status              r_out_st, n_out_st;
    logic [COORD_BITS-1:0] r_out_x, n_out_x, r_out_y, n_out_y;
    logic [COORD_BITS:0]   r_out_dx, n_out_dx, r_out_dy, n_out_dy;

    logic                 out_free;
    logic                 take;
    logic [TIME_BITS-1:0] gap;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_valid && ((i_cmd != CMD_READ) || out_free);
    assign take     = o_pop;
    assign gap      = i_time - r_last_t;

    always_comb begin
        n_prev   = r_prev;
        n_pub    = r_pub;
        n_pub_x  = r_pub_x;
        n_pub_y  = r_pub_y;
        n_pub_dx = r_pub_dx;
        n_pub_dy = r_pub_dy;
        n_anc_x  = r_anc_x;
        n_anc_y  = r_anc_y;
        n_unread = r_unread;
        n_last_t = r_last_t;
        n_seen   = r_seen;

        n_out_valid = r_out_valid && !i_ready;
        n_out_fresh = r_out_fresh;
        n_out_st    = r_out_st;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_dx    = r_out_dx;
        n_out_dy    = r_out_dy;

        if (take) begin
            case (i_cmd)
                CMD_READ: begin
                    n_out_valid = 1'b1;
                    n_out_fresh = r_unread;
                    if (r_unread) begin
                        n_out_st = r_pub;
                        n_out_x  = r_pub_x;
                        n_out_y  = r_pub_y;
                        n_out_dx = r_pub_dx;
                        n_out_dy = r_pub_dy;
                    end else begin
                        n_out_st = ST_IDLE;
                        n_out_x  = '0;
                        n_out_y  = '0;
                        n_out_dx = '0;
                        n_out_dy = '0;
                    end
                    n_unread = 1'b0;
                end
                CMD_PEN_UP: begin
                    // Samples are ignored while the record waits to be read.
                    if (!r_unread) begin
                        n_unread = 1'b1;
                        if (pen_down(r_prev)) begin
                            n_prev   = ST_RELEASE;
                            n_pub    = ST_RELEASE;
                            n_pub_x  = i_x;
                            n_pub_y  = i_y;
                            n_pub_dx = '0;
                            n_pub_dy = '0;
                            n_anc_x  = i_x;
                            n_anc_y  = i_y;
                        end else begin
                            n_prev  = ST_IDLE;
                            n_pub   = ST_IDLE;
                            n_anc_x = '0;
                            n_anc_y = '0;
                        end
                    end
                end
                CMD_TOUCH: begin
                    if (!r_unread) begin
                        n_unread = 1'b1;
                        n_pub_x  = i_x;
                        n_pub_y  = i_y;
                        n_anc_x  = i_x;
                        n_anc_y  = i_y;
                        if (pen_down(r_prev)) begin
                            n_prev   = ST_HELD;
                            n_pub    = ST_HELD;
                            n_pub_dx = r_pub_dx + {1'b0, i_x} - {1'b0, r_anc_x};
                            n_pub_dy = r_pub_dy + {1'b0, i_y} - {1'b0, r_anc_y};
                        end else begin
                            n_prev   = ST_PRESS;
                            n_pub    = ST_PRESS;
                            n_pub_dx = '0;
                            n_pub_dy = '0;
                            if (r_seen && (gap < {{(TIME_BITS-IVAL_BITS){1'b0}}, r_ival})) begin
                                n_pub = ST_DOUBLE;
                            end
                            n_last_t = i_time;
                            n_seen   = 1'b1;
                        end
                    end
                end
                default: begin
                    n_unread = r_unread;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ival      <= IVAL_RESET;
            r_prev      <= ST_IDLE;
            r_pub       <= ST_IDLE;
            r_pub_x     <= '0;
            r_pub_y     <= '0;
            r_pub_dx    <= '0;
            r_pub_dy    <= '0;
            r_anc_x     <= '0;
            r_anc_y     <= '0;
            r_unread    <= 1'b0;
            r_last_t    <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ival <= i_cfg_wdata;
            end
            r_prev      <= n_prev;
            r_pub       <= n_pub;
            r_pub_x     <= n_pub_x;
            r_pub_y     <= n_pub_y;
            r_pub_dx    <= n_pub_dx;
            r_pub_dy    <= n_pub_dy;
            r_anc_x     <= n_anc_x;
            r_anc_y     <= n_anc_y;
            r_unread    <= n_unread;
            r_last_t    <= n_last_t;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_fresh <= n_out_fresh;
        r_out_st    <= n_out_st;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_dx    <= n_out_dx;
        r_out_dy    <= n_out_dy;
    end

    assign o_valid  = r_out_valid;
    assign o_fresh  = r_out_fresh;
    assign o_status = r_out_st;
    assign o_x      = r_out_x;
    assign o_y      = r_out_y;
    assign o_dx     = r_out_dx;
    assign o_dy     = r_out_dy;

endmodule

// File: src/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: front end, queue, back end.
// Depends on tgc_pkg, tgc_front, tgc_queue and tgc_back.
//
//  Channel           Direction  Carries
//  i_s_*, o_s_tready in         touch samples and read requests (tuser: op)
//  o_m_*, i_m_tready out        one record for each read request (tuser: fresh)
//  i_cfg_*           in         double press interval in microseconds
//
// One item is taken per cycle while the queue has room; the back end carries out
// one command a cycle unless a read waits for the output. A read request waits at
// the queue head until the output register is free, then loads its record into it.
// Reset clears the gesture state, the queue and the output valid flag.
// A stall on the output holds only read requests: samples keep flowing
// until the two-entry queue fills behind a waiting read.
module touch_gesture_classifier #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tgc_pkg::IVAL_BITS-1:0] i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // Fields from bit 0: read_status, sample_x, sample_y, time_us.
    input  logic [((2+2*COORD_BITS+tgc_pkg::TIME_BITS+7)/8)*8-1:0] i_s_tdata,
    // Fields from bit 0: op.
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // Fields from bit 0: touch_status, coord_x, coord_y, drag_dx, drag_dy.
    output logic [((3+4*COORD_BITS+2+7)/8)*8-1:0] o_m_tdata,
    // Fields from bit 0: fresh.
    output logic                          o_m_tuser
);
    import tgc_pkg::*;

    localparam int OUT_W = ((3 + 4*COORD_BITS + 2 + 7) / 8) * 8;
    localparam int Q_W   = 2 + 2*COORD_BITS + TIME_BITS;

    logic                  push, q_ready, q_valid, pop;
    t_cmd                  f_cmd, b_cmd;
    logic [COORD_BITS-1:0] f_x, f_y, b_x, b_y;
    logic [TIME_BITS-1:0]  f_time, b_time;
    logic [Q_W-1:0]        q_in, q_out;

    t_status               st;
    logic [COORD_BITS-1:0] ox, oy;
    logic [COORD_BITS:0]   odx, ody;

    tgc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_op          (i_s_tuser),
        .i_read_status (i_s_tdata[1:0]),
        .i_x           (i_s_tdata[2 +: COORD_BITS]),
        .i_y           (i_s_tdata[2+COORD_BITS +: COORD_BITS]),
        .i_time        (i_s_tdata[2+2*COORD_BITS +: TIME_BITS]),
        .o_push        (push),
        .o_cmd         (f_cmd),
        .o_x           (f_x),
        .o_y           (f_y),
        .o_time        (f_time),
        .i_q_ready     (q_ready)
    );

    assign q_in = {f_time, f_y, f_x, f_cmd};

    tgc_queue #(.WIDTH(Q_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign b_cmd  = t_cmd'(q_out[1:0]);
    assign b_x    = q_out[2 +: COORD_BITS];
    assign b_y    = q_out[2+COORD_BITS +: COORD_BITS];
    assign b_time = q_out[2+2*COORD_BITS +: TIME_BITS];

    tgc_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .o_pop       (pop),
        .i_cmd       (b_cmd),
        .i_x         (b_x),
        .i_y         (b_y),
        .i_time      (b_time),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_fresh     (o_m_tuser),
        .o_status    (st),
        .o_x         (ox),
        .o_y         (oy),
        .o_dx        (odx),
        .o_dy        (ody)
    );

    assign o_m_tdata = OUT_W'({ody, odx, oy, ox, st});

endmodule

// File: tb/sv/tgc_tb_pkg.sv
`timescale 1ns / 1ps
// Checker class for the touch gesture classifier testbench: tracks the gesture
// state from accepted input transfers and checks every returned record. Depends on tgc_pkg.
package tgc_tb_pkg;
    import tgc_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    // The reader never sends this code; the block must treat it as a busy reading.
    localparam logic [1:0] RS_UNDEF = 2'd3;

    typedef struct {
        logic            fresh;
        t_status         st;
        logic [CB-1:0]   x;
        logic [CB-1:0]   y;
        logic [CB:0]     dx;
        logic [CB:0]     dy;
    } t_touch_record;

    class gesture_checker;
        int unsigned     errors;
        logic [23:0]     ival;
        t_status         prev_st;
        t_status         pub_st;
        logic [CB-1:0]   pub_x;
        logic [CB-1:0]   pub_y;
        logic [CB:0]     pub_dx;
        logic [CB:0]     pub_dy;
        logic [CB-1:0]   anc_x;
        logic [CB-1:0]   anc_y;
        logic            unread;
        logic            press_seen;
        logic [31:0]     last_press;
        t_touch_record   records_due[$];

        function new();
            errors     = 0;
            ival       = IVAL_RESET;
            prev_st    = ST_IDLE;
            pub_st     = ST_IDLE;
            pub_x      = '0;
            pub_y      = '0;
            pub_dx     = '0;
            pub_dy     = '0;
            anc_x      = '0;
            anc_y      = '0;
            unread     = 1'b0;
            press_seen = 1'b0;
            last_press = '0;
        endfunction

        function void set_interval(logic [23:0] v);
            ival = v;
        endfunction

        function int pending();
            return records_due.size();
        endfunction

        function logic pen_is_down();
            return (prev_st == ST_PRESS) || (prev_st == ST_HELD) || (prev_st == ST_DOUBLE);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Update the gesture state for one accepted input transfer.
        function void classify_item(logic op, logic [1:0] rs, logic [CB-1:0] x,
                                    logic [CB-1:0] y, logic [31:0] t);
            t_touch_record r;
            logic [31:0]   gap;
            if (op == OP_READ) begin
                if (unread) begin
                    r.fresh = 1'b1;
                    r.st    = pub_st;
                    r.x     = pub_x;
                    r.y     = pub_y;
                    r.dx    = pub_dx;
                    r.dy    = pub_dy;
                    unread  = 1'b0;
                end else begin
                    r.fresh = 1'b0;
                    r.st    = ST_IDLE;
                    r.x     = '0;
                    r.y     = '0;
                    r.dx    = '0;
                    r.dy    = '0;
                end
                records_due.push_back(r);
                return;
            end
            // An unread record locks out every sample.
            if (unread)
                return;
            if (rs == RS_PEN_UP) begin
                if (pen_is_down()) begin
                    prev_st = ST_RELEASE;
                    pub_st  = ST_RELEASE;
                    pub_x   = x;
                    pub_y   = y;
                    pub_dx  = '0;
                    pub_dy  = '0;
                    anc_x   = x;
                    anc_y   = y;
                end else begin
                    prev_st = ST_IDLE;
                    pub_st  = ST_IDLE;
                    anc_x   = '0;
                    anc_y   = '0;
                end
                unread = 1'b1;
            end else if (rs == RS_COMPLETE) begin
                if (pen_is_down()) begin
                    prev_st = ST_HELD;
                    pub_st  = ST_HELD;
                    pub_dx  = pub_dx + {1'b0, x} - {1'b0, anc_x};
                    pub_dy  = pub_dy + {1'b0, y} - {1'b0, anc_y};
                end else begin
                    gap     = t - last_press;
                    prev_st = ST_PRESS;
                    pub_st  = (press_seen && gap < {8'd0, ival}) ? ST_DOUBLE : ST_PRESS;
                    pub_dx  = '0;
                    pub_dy  = '0;
                    last_press = t;
                    press_seen = 1'b1;
                end
                pub_x  = x;
                pub_y  = y;
                anc_x  = x;
                anc_y  = y;
                unread = 1'b1;
            end
        endfunction

        // Compare one output transfer with the oldest record due.
        task check_record(logic [55:0] d, logic fresh);
            t_touch_record e;
            if (records_due.size() == 0) begin
                report("record returned while none was due");
                return;
            end
            e = records_due.pop_front();
            if (fresh !== e.fresh)
                report($sformatf("fresh got %0b want %0b", fresh, e.fresh));
            if (d[2:0] !== e.st)
                report($sformatf("status got %0d want %0d", d[2:0], e.st));
            if (d[14:3] !== e.x)
                report($sformatf("coord_x got %0d want %0d", d[14:3], e.x));
            if (d[26:15] !== e.y)
                report($sformatf("coord_y got %0d want %0d", d[26:15], e.y));
            if (d[39:27] !== e.dx)
                report($sformatf("drag_dx got %h want %h", d[39:27], e.dx));
            if (d[52:40] !== e.dy)
                report($sformatf("drag_dy got %h want %h", d[52:40], e.dy));
        endtask
    endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the touch gesture classifier testbench: clock, reset, stream drivers
// and stimulus. Depends on tgc_pkg, tgc_tb_pkg and touch_gesture_classifier.
module tb_top;
    import tgc_pkg::*;
    import tgc_tb_pkg::*;

    localparam int unsigned LIMIT = 200000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [IVAL_BITS-1:0] i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [63:0]          i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [55:0]          o_m_tdata;
    logic                 o_m_tuser;

    gesture_checker gc = new();

    logic           no_idle  = 1'b0;
    logic           hold_req = 1'b0;
    int unsigned    cycles   = 0;
    int unsigned    ival_now = IVAL_RESET;
    logic [31:0]    cur_time = '0;
    logic [CB-1:0]  gx       = '0;
    logic [CB-1:0]  gy       = '0;

    touch_gesture_classifier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_m_tready <= no_idle || ($urandom_range(99) >= 26);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            gc.check_record(o_m_tdata, o_m_tuser);
    end

    task automatic send_item(input logic op, input logic [1:0] rs, input logic [CB-1:0] x,
                             input logic [CB-1:0] y, input logic [31:0] t);
        while (!no_idle && $urandom_range(99) < 26) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {6'd0, t, y, x, rs};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        gc.classify_item(op, rs, x, y, t);
    endtask

    // Reads ignore the data fields, so they carry random bits.
    task automatic send_read();
        send_item(OP_READ, 2'($urandom_range(3)), CB'($urandom_range(4095)),
                  CB'($urandom_range(4095)), $urandom());
    endtask

    task automatic drain_records();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (gc.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [23:0] v);
        drain_records();
        // Samples give no result, so let the pipeline empty before the write.
        repeat (10) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gc.set_interval(v);
        ival_now = v;
    endtask

    function automatic logic [CB-1:0] move_coord(logic [CB-1:0] c);
        int unsigned r;
        int          n;
        r = $urandom_range(15);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 4)
            return CB'($urandom_range(4095));
        n = int'(c) + int'($urandom_range(80)) - 40;
        if (n < 0)
            n = 0;
        if (n > 4095)
            n = 4095;
        return CB'(n);
    endfunction

    task automatic send_random_item();
        int unsigned r;
        logic [1:0]  rs;
        r = $urandom_range(99);
        // Mostly a sample followed by its read, with stray reads and dropped samples.
        if (gc.unread ? (r < 85) : (r < 8)) begin
            send_read();
        end else begin
            r = $urandom_range(99);
            if (r < 55)
                rs = RS_COMPLETE;
            else if (r < 80)
                rs = RS_PEN_UP;
            else if (r < 90)
                rs = RS_BUSY;
            else
                rs = RS_UNDEF;
            if ($urandom_range(19) == 0)
                cur_time = $urandom();
            else
                cur_time = cur_time + $urandom_range(ival_now / 3 + 50);
            gx = move_coord(gx);
            gy = move_coord(gy);
            send_item(OP_SAMPLE, rs, gx, gy, cur_time);
        end
    endtask

    task automatic run_random(input int n, input int phase);
        for (int i = 0; i < n; i++) begin
            if (phase == 1)
                no_idle = (i >= 40 && i < 240);
            if (phase == 2 && i == 60)
                hold_req = 1'b1;
            if (phase == 3 && i == 150)
                drain_records();
            send_random_item();
        end
        no_idle = 1'b0;
    endtask

    task automatic run_directed();
        send_read();
        send_item(OP_SAMPLE, RS_PEN_UP, 12'd5, 12'd6, 32'hFFFF_FFFF);
        send_read();
        // First press after reset at time zero: a plain press.
        send_item(OP_SAMPLE, RS_COMPLETE, 12'd0, 12'd0, 32'd0);
        send_item(OP_SAMPLE, RS_COMPLETE, 12'd4095, 12'd4095, 32'd50);
        send_read();
        send_item(OP_SAMPLE, RS_COMPLETE, 12'd4095, 12'd4095, 32'd200);
        send_read();
        send_item(OP_SAMPLE, RS_BUSY, 12'd4095, 12'd0, 32'd300);
        send_item(OP_SAMPLE, RS_UNDEF, 12'd0, 12'd4095, 32'd310);
        send_read();
        send_item(OP_SAMPLE, RS_PEN_UP, 12'd4095, 12'd4095, 32'd400);
        send_read();
        // One microsecond inside the interval: a double press.
        send_item(OP_SAMPLE, RS_COMPLETE, 12'd4095, 12'd4095, 32'd299999);
        send_read();
        send_item(OP_SAMPLE, RS_COMPLETE, 12'd0, 12'd0, 32'd300100);
        send_read();
        send_item(OP_SAMPLE, RS_PEN_UP, 12'd1, 12'd2, 32'd300200);
        send_read();
        send_item(OP_SAMPLE, RS_PEN_UP, 12'd7, 12'd8, 32'd300300);
        send_read();
        // Exactly the interval after the last press: not a double press.
        send_item(OP_SAMPLE, RS_COMPLETE, 12'd2048, 12'd1024, 32'd599999);
        send_read();
        send_read();
        cur_time = 32'd600000;
        gx = 12'd2048;
        gy = 12'd1024;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(290, 0);
        write_interval(24'd0);
        run_random(290, 1);
        write_interval(24'hFF_FFFF);
        run_random(290, 2);
        write_interval(24'($urandom_range(24'hFF_FFFF)));
        run_random(290, 3);
        write_interval(24'd1);
        run_random(290, 4);
        write_interval(24'd2000);
        run_random(290, 5);
        drain_records();
        repeat (20) @(posedge i_clk);
        if (gc.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
src/tgc_pkg.sv
src/tgc_front.sv
src/tgc_queue.sv
src/tgc_back.sv
src/touch_gesture_classifier.sv
tb/sv/tgc_tb_pkg.sv
tb/sv/tb_top.sv
